// File: hdl/palette_quantize_tile_packer_unit_macros.svh
`ifndef PALETTE_QUANTIZE_TILE_PACKER_UNIT_MACROS_SVH
`define PALETTE_QUANTIZE_TILE_PACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PQT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pqt assertion failed");

`define PQT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pqt assertion failed");

`else

`define PQT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define PQT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/pqt_pkg.sv
package pqt_pkg;

    localparam int PALETTE_ENTRIES    = 16;
    localparam int MAX_TILES_PER_SIDE = 512;

    localparam int IDX_W      = $clog2(PALETTE_ENTRIES);
    localparam int TILE_W     = 10;
    localparam int COUNT_W    = 12;
    localparam int PIX_W      = TILE_W + 3;
    localparam int TILE_NUM_W = COUNT_W - 3 + TILE_W + 1;
    localparam int ADDR_W     = 23;
    localparam int CH_W       = 8;
    localparam int NIB_W      = 4;
    localparam int PIDX_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 3 * CH_W;
    localparam int DIST_W     = 18;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic
    {
        CMD_PALETTE = 1'b0,
        CMD_PIXEL   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_WIDTH_IN_TILES  = 1'b0,
        REG_HEIGHT_IN_TILES = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [PIDX_W-1:0] palette_index;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              frame_start;
    } pqt_in_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } pqt_out_t;

    typedef struct packed
    {
        logic              odd;
        logic [ADDR_W-1:0] byte_address;
        logic              last_byte;
    } side_t;

    typedef struct packed
    {
        logic              valid;
        pqt_in_t           item;
        side_t             side;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } stage_t;

    function automatic logic [TILE_W-1:0] clamp_tiles(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        if (v == '0)
            r = TILE_W'(1);
        else if (int'(v) > MAX_TILES_PER_SIDE)
            r = TILE_W'(MAX_TILES_PER_SIDE);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] reset_color(input logic [IDX_W-1:0] k);
        logic [CH_W-1:0] v;
        v = CH_W'(int'(k) * 17);
        return {{CH_W{1'b0}}, v, v};
    endfunction

endpackage

// File: hdl/pqt_coord.sv
module pqt_coord
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  pqt_pkg::pqt_in_t              in_data,
    input  logic                          cfg_write_en,
    input  logic [pqt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pqt_pkg::TILE_W-1:0]    cfg_data,
    output pqt_pkg::side_t                side
);

    logic [pqt_pkg::TILE_W-1:0]     width_reg, width_next;
    logic [pqt_pkg::TILE_W-1:0]     height_reg, height_next;
    logic [pqt_pkg::COUNT_W-1:0]    col_reg, col_next;
    logic [pqt_pkg::COUNT_W-1:0]    row_reg, row_next;
    logic [pqt_pkg::TILE_W-1:0]     wt, ht;
    logic [pqt_pkg::PIX_W-1:0]      wpix, hpix;
    logic [pqt_pkg::COUNT_W-1:0]    col_eff, row_eff;
    logic [pqt_pkg::PIX_W-1:0]      col_inc, row_inc;
    logic [pqt_pkg::TILE_NUM_W-1:0] tile;

    always_comb
    begin
        wt      = pqt_pkg::clamp_tiles(width_reg);
        ht      = pqt_pkg::clamp_tiles(height_reg);
        wpix    = {wt, 3'b000};
        hpix    = {ht, 3'b000};
        col_eff = in_data.frame_start ? '0 : col_reg;
        row_eff = in_data.frame_start ? '0 : row_reg;
        col_inc = pqt_pkg::PIX_W'(col_eff) + pqt_pkg::PIX_W'(1);
        row_inc = pqt_pkg::PIX_W'(row_eff) + pqt_pkg::PIX_W'(1);

        tile = pqt_pkg::TILE_NUM_W'(row_eff[pqt_pkg::COUNT_W-1:3])
             * pqt_pkg::TILE_NUM_W'(wt)
             + pqt_pkg::TILE_NUM_W'(col_eff[pqt_pkg::COUNT_W-1:3]);

        side.odd          = col_eff[0];
        side.byte_address = pqt_pkg::ADDR_W'({tile, row_eff[2:0], col_eff[2:1]});
        side.last_byte    = (pqt_pkg::PIX_W'(row_eff) == hpix - pqt_pkg::PIX_W'(1))
                         && (pqt_pkg::PIX_W'(col_eff) == wpix - pqt_pkg::PIX_W'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (accept && in_data.cmd == pqt_pkg::CMD_PIXEL)
        begin
            if (col_inc >= wpix)
            begin
                col_next = '0;
                row_next = (row_inc >= hpix) ? '0 : row_inc[pqt_pkg::COUNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[pqt_pkg::COUNT_W-1:0];
                row_next = row_eff;
            end
        end

        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write_en)
        begin
            unique case (pqt_pkg::cfg_reg_t'(cfg_index))
                pqt_pkg::REG_WIDTH_IN_TILES:  width_next  = cfg_data;
                pqt_pkg::REG_HEIGHT_IN_TILES: height_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pqt_pkg::TILE_W'(1);
            height_reg <= pqt_pkg::TILE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: hdl/pqt_cell.sv
module pqt_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [pqt_pkg::IDX_W-1:0] cell_index,
    input  pqt_pkg::stage_t           stage_in,
    output pqt_pkg::stage_t           stage_out
);

    logic [pqt_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic                         written_reg, written_next;
    logic [pqt_pkg::COLOR_W-1:0]  color;
    logic [pqt_pkg::CH_W-1:0]     dr, dg, db;
    logic [2*pqt_pkg::CH_W-1:0]   sq_r, sq_g, sq_b;
    logic [pqt_pkg::DIST_W-1:0]   sum_sq;
    logic                         write_hit;
    pqt_pkg::stage_t              stage_reg, stage_next;

    function automatic logic [pqt_pkg::CH_W-1:0] abs_diff(
        input logic [pqt_pkg::CH_W-1:0] a,
        input logic [pqt_pkg::CH_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        color = written_reg ? color_reg : pqt_pkg::reset_color(cell_index);

        dr     = abs_diff(color[3*pqt_pkg::CH_W-1:2*pqt_pkg::CH_W], stage_in.item.red);
        dg     = abs_diff(color[2*pqt_pkg::CH_W-1:pqt_pkg::CH_W], stage_in.item.green);
        db     = abs_diff(color[pqt_pkg::CH_W-1:0], stage_in.item.blue);
        sq_r   = dr * dr;
        sq_g   = dg * dg;
        sq_b   = db * db;
        sum_sq = pqt_pkg::DIST_W'(sq_r) + pqt_pkg::DIST_W'(sq_g) + pqt_pkg::DIST_W'(sq_b);

        stage_next = stage_in;
        if (stage_in.item.cmd == pqt_pkg::CMD_PIXEL && sum_sq < stage_in.best_dist)
        begin
            stage_next.best_dist = sum_sq;
            stage_next.best_idx  = cell_index;
        end

        write_hit = advance && stage_in.valid
                 && stage_in.item.cmd == pqt_pkg::CMD_PALETTE
                 && int'(stage_in.item.palette_index) == int'(cell_index);

        color_next   = write_hit
                     ? {stage_in.item.red, stage_in.item.green, stage_in.item.blue}
                     : color_reg;
        written_next = written_reg || write_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg     <= 1'b0;
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (advance)
                stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign stage_out = stage_reg;

endmodule

// File: hdl/pqt_pack.sv
module pqt_pack
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  pqt_pkg::stage_t   tail,
    output logic              out_valid,
    output pqt_pkg::pqt_out_t tile_byte
);

    logic [pqt_pkg::NIB_W-1:0] pending_reg, pending_next;
    logic                      out_valid_reg, out_valid_next;
    pqt_pkg::pqt_out_t         out_reg, out_next;
    logic [pqt_pkg::NIB_W-1:0] nibble;
    logic                      is_pixel;

    always_comb
    begin
        nibble   = pqt_pkg::NIB_W'(tail.best_idx);
        is_pixel = tail.valid && tail.item.cmd == pqt_pkg::CMD_PIXEL;

        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = is_pixel && tail.side.odd;
            if (is_pixel && !tail.side.odd)
                pending_next = nibble;
            if (is_pixel && tail.side.odd)
            begin
                out_next.byte_address = tail.side.byte_address;
                out_next.byte_value   = {nibble, pending_reg};
                out_next.last_byte    = tail.side.last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign tile_byte = out_reg;

endmodule

// File: hdl/palette_quantize_tile_packer_unit.sv
// Palette quantizer and 4bpp tile packer.
// Input channel (in_valid/in_ready/in_data): one word per palette write or per pixel,
// pixels in raster order; frame_start on a pixel restarts row and column at zero.
// Output channel (out_valid/out_ready/tile_byte): one word per pixel pair, the even
// column index in the low nibble, with its byte address in 8x8-tile order and a flag
// on the last byte of the image. Palette writes and even pixels produce no word.
// Configuration: cfg_write_en/cfg_index/cfg_data set tiles per row (index 0) and
// tile rows (index 1); write only while the block is idle.
// Throughput: one input word per cycle while the chain is not stalled; a new word
// enters before earlier ones leave. A word travels through a chain of 16 cells,
// one palette entry each, then the output register. Palette writes ride the same
// chain, so they take effect in order with the pixels around them.
// Reset: palette entry k becomes red 0, green and blue 17k; counters clear;
// both size registers read 1. No clearing pass is needed.
// Stall: while a result waits on out_ready low, the whole chain holds and
// in_ready drops in the same cycle.
`include "palette_quantize_tile_packer_unit_macros.svh"

module palette_quantize_tile_packer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pqt_pkg::pqt_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pqt_pkg::pqt_out_t             tile_byte,
    input  logic                          cfg_write_en,
    input  logic [pqt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pqt_pkg::TILE_W-1:0]    cfg_data
);

    logic            advance;
    logic            accept;
    pqt_pkg::side_t  side;
    pqt_pkg::stage_t head;
    pqt_pkg::stage_t chain [0:pqt_pkg::PALETTE_ENTRIES];
    logic            tail_odd_pixel;
    logic            last_corner;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    pqt_coord u_coord
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_data      (in_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .side         (side)
    );

    always_comb
    begin
        head.valid     = accept;
        head.item      = in_data;
        head.side      = side;
        head.best_dist = '1;
        head.best_idx  = '0;
    end

    assign chain[0] = head;

    for (genvar k = 0; k < pqt_pkg::PALETTE_ENTRIES; k++)
    begin : g_cell
        pqt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (pqt_pkg::IDX_W'(k)),
            .stage_in   (chain[k]),
            .stage_out  (chain[k+1])
        );
    end

    pqt_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tail      (chain[pqt_pkg::PALETTE_ENTRIES]),
        .out_valid (out_valid),
        .tile_byte (tile_byte)
    );

    assign tail_odd_pixel = advance && chain[pqt_pkg::PALETTE_ENTRIES].valid
                         && chain[pqt_pkg::PALETTE_ENTRIES].item.cmd == pqt_pkg::CMD_PIXEL
                         && chain[pqt_pkg::PALETTE_ENTRIES].side.odd;
    assign last_corner    = &tile_byte.byte_address[4:0];

    `PQT_ASSERT_SAME(a_last_tile_corner, clk, rst_n, out_valid && tile_byte.last_byte, last_corner)
    `PQT_ASSERT_NEXT(a_odd_pixel_emits, clk, rst_n, tail_odd_pixel, out_valid)
    `PQT_ASSERT_NEXT(a_accept_enters_chain, clk, rst_n, accept, chain[1].valid)

endmodule
